/* rtl/pipx_pkg.sv */
// pipx_pkg: shared types, constants and helper functions of the palette expander
// used by every rtl module of the block except pipx_ram; depends on nothing else

package pipx_pkg;

    // palette store and row geometry
    localparam int PAL_ENTRIES   = 256;
    localparam int PAL_AW        = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int MAX_ROW_WIDTH = 4096;

    // fixed field widths
    localparam int IDX_W   = 8;
    localparam int ARGB_W  = 32;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IW  = 2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam int         GRAY_MAX     = 255;

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_DEPTH     = 2'd0,
        CFG_GRAY      = 2'd1,
        CFG_ROW_WIDTH = 2'd2
    } t_cfg_idx;

    // bits per pixel codes
    typedef enum logic [1:0] {
        DEPTH_1 = 2'd0,
        DEPTH_2 = 2'd1,
        DEPTH_4 = 2'd2,
        DEPTH_8 = 2'd3
    } t_depth;

    // input item functions
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_PIXEL = 1'b1
    } t_func;

    typedef struct packed {
        logic                func;
        logic [IDX_W-1:0]    entry_index;
        logic [ARGB_W-1:0]   entry_argb;
        logic [7:0]          packed_byte;
    } t_in_item;

    typedef struct packed {
        logic [ARGB_W-1:0]   argb;
        logic [COL_W-1:0]    column;
        logic                last_of_byte;
        logic                row_end;
    } t_out_item;

    // one pixel leaving the unpacker
    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    idx;
        logic [COL_W-1:0]    column;
        logic                last_of_byte;
        logic                row_end;
    } t_pix;

    // palette write request
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [ARGB_W-1:0]   data;
    } t_pal_wr;

    // opaque gray ramp level, idx*255/(levels-1)
    function automatic logic [7:0] gray_level(input logic [IDX_W-1:0] idx, input t_depth depth);
        logic [15:0] prod;
        begin
            unique case (depth)
                DEPTH_1: prod = idx[0] ? 16'(GRAY_MAX) : 16'd0;
                DEPTH_2: prod = 16'(idx[1:0]) * 16'(GRAY_MAX / 3);
                DEPTH_4: prod = 16'(idx[3:0]) * 16'(GRAY_MAX / 15);
                DEPTH_8: prod = 16'(idx);
                default: prod = 16'd0;
            endcase
            return prod[7:0];
        end
    endfunction

endpackage

/* rtl/pipx_ram.sv */
// pipx_ram: generic single write port, single read port ram with registered read
// no dependencies

module pipx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pipx_unpack.sv */
// pipx_unpack: input register, msb-first pixel slicer and row column counter
// depends on pipx_pkg

module pipx_unpack
    import pipx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in_item         i_item,
    output logic             o_stall,
    input  t_depth           i_depth,
    input  logic [ROW_W-1:0] i_width,
    input  logic             i_s2_ready,
    output t_pix             o_pix,
    output t_pal_wr          o_wr
);

    logic              r_busy;
    logic              r_func;
    logic [7:0]        r_byte;
    logic [2:0]        r_slot;
    logic [IDX_W-1:0]  r_entry;
    logic [ARGB_W-1:0] r_argb;
    logic [COL_W-1:0]  r_col;

    logic [IDX_W-1:0]  idx;
    logic [7:0]        byte_shift;
    logic [2:0]        last_slot;
    logic [COL_W-1:0]  col_eff;
    logic [ROW_W-1:0]  col_inc;
    logic              row_end;
    logic              pix_valid;
    logic              issue;
    logic              done;
    logic              accept;

    always_comb begin
        unique case (i_depth)
            DEPTH_1: begin
                idx        = IDX_W'(r_byte[7]);
                byte_shift = {r_byte[6:0], 1'b0};
                last_slot  = 3'd7;
            end
            DEPTH_2: begin
                idx        = IDX_W'(r_byte[7:6]);
                byte_shift = {r_byte[5:0], 2'b0};
                last_slot  = 3'd3;
            end
            DEPTH_4: begin
                idx        = IDX_W'(r_byte[7:4]);
                byte_shift = {r_byte[3:0], 4'b0};
                last_slot  = 3'd1;
            end
            DEPTH_8: begin
                idx        = r_byte;
                byte_shift = 8'd0;
                last_slot  = 3'd0;
            end
            default: begin
                idx        = r_byte;
                byte_shift = 8'd0;
                last_slot  = 3'd0;
            end
        endcase
    end

    // a column left beyond a lowered row width restarts the row
    assign col_eff   = ({1'b0, r_col} >= i_width) ? '0 : r_col;
    assign col_inc   = {1'b0, col_eff} + ROW_W'(1);
    assign row_end   = (col_inc == i_width);

    assign pix_valid = r_busy && (r_func == FUNC_PIXEL);
    assign issue     = pix_valid && i_s2_ready;
    assign done      = r_busy && ((r_func == FUNC_LOAD) ||
                                  (issue && ((r_slot == last_slot) || row_end)));
    assign o_stall   = r_busy && !done;
    assign accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_col  <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (issue) begin
                r_col <= row_end ? '0 : col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_item.func;
            r_byte  <= i_item.packed_byte;
            r_slot  <= 3'd0;
            r_entry <= i_item.entry_index;
            r_argb  <= i_item.entry_argb;
        end else if (issue) begin
            r_byte <= byte_shift;
            r_slot <= r_slot + 3'd1;
        end
    end

    always_comb begin
        o_pix.valid        = pix_valid;
        o_pix.idx          = idx;
        o_pix.column       = col_eff;
        o_pix.last_of_byte = (r_slot == last_slot) || row_end;
        o_pix.row_end      = row_end;
        o_wr.en            = r_busy && (r_func == FUNC_LOAD);
        o_wr.addr          = r_entry;
        o_wr.data          = r_argb;
    end

endmodule

/* rtl/pipx_colour.sv */
// pipx_colour: palette store with valid bits, colour select and output register
// depends on pipx_pkg and pipx_ram

module pipx_colour
    import pipx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pix      i_pix,
    input  t_pal_wr   i_wr,
    input  logic      i_gray,
    input  t_depth    i_depth,
    output logic      o_s2_ready,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [PAL_ENTRIES-1:0] r_pal_vld;
    logic                   r_s2_valid;
    logic [IDX_W-1:0]       r_s2_idx;
    logic [COL_W-1:0]       r_s2_column;
    logic                   r_s2_last;
    logic                   r_s2_row_end;
    logic                   r_s2_hit;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    logic                   wr_ok;
    logic                   rd_ok;
    logic                   rd_en;
    logic                   s3_ready;
    logic [ARGB_W-1:0]      ram_rdata;
    logic [7:0]             gray;
    logic [ARGB_W-1:0]      colour;

    assign wr_ok      = i_wr.en && ({1'b0, i_wr.addr} < (IDX_W + 1)'(PAL_ENTRIES));
    assign rd_ok      = {1'b0, i_pix.idx} < (IDX_W + 1)'(PAL_ENTRIES);
    assign s3_ready   = !r_out_valid || !i_out_stall;
    assign o_s2_ready = !r_s2_valid || s3_ready;
    assign rd_en      = i_pix.valid && o_s2_ready;

    pipx_ram #(
        .WIDTH (ARGB_W),
        .DEPTH (PAL_ENTRIES)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (i_wr.addr[PAL_AW-1:0]),
        .i_wdata (i_wr.data),
        .i_re    (rd_en),
        .i_raddr (i_pix.idx[PAL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (wr_ok) begin
            r_pal_vld[i_wr.addr[PAL_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s2_ready) begin
                r_s2_valid <= i_pix.valid;
            end
            if (s3_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s2_idx     <= i_pix.idx;
            r_s2_column  <= i_pix.column;
            r_s2_last    <= i_pix.last_of_byte;
            r_s2_row_end <= i_pix.row_end;
            r_s2_hit     <= rd_ok && r_pal_vld[i_pix.idx[PAL_AW-1:0]];
        end
        if (s3_ready && r_s2_valid) begin
            r_out_data.argb         <= colour;
            r_out_data.column       <= r_s2_column;
            r_out_data.last_of_byte <= r_s2_last;
            r_out_data.row_end      <= r_s2_row_end;
        end
    end

    assign gray   = gray_level(r_s2_idx, i_depth);
    assign colour = i_gray   ? {ALPHA_OPAQUE, gray, gray, gray} :
                    r_s2_hit ? ram_rdata : '0;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/packed_index_palette_expander_top.sv */
// packed_index_palette_expander_top: top level of the packed pixel palette expander
// depends on pipx_pkg, pipx_unpack and pipx_colour (which holds pipx_ram)
//
// Expands packed 1, 2, 4 or 8 bit pixel indices to 32-bit ARGB, one pixel per
// clock on the output channel while it is not stalled. A load transaction
// (func 0) writes one palette word and never stalls the input; it produces
// nothing. A pixel transaction (func 1) occupies the input register until it
// has yielded its pixels: 8/bpp of them, fewer when the row ends inside the
// byte, so a 1 bpp byte yields 8 pixels, a 2 bpp byte 4, a 4 bpp byte 2, an
// 8 bpp byte 1. The next transaction is taken in the cycle the last pixel of
// the current one leaves the unpacker. After a byte is taken, its first pixel
// passes through the registered palette read, then colour select, into the
// output register. The palette store is cleared at reset through per-entry
// valid bits, so there is no clearing pass and the block is ready right after
// reset. Configuration registers take effect at once and are not held back,
// so write them only while no transaction is in flight.

module packed_index_palette_expander_top
    import pipx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    // configuration registers
    t_depth           r_depth;
    logic             r_gray;
    logic [ROW_W-1:0] r_row_width;

    logic [ROW_W-1:0] width_eff;
    logic             s2_ready;
    t_pix             pix;
    t_pal_wr          pal_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= DEPTH_8;
            r_gray      <= 1'b0;
            r_row_width <= ROW_W'(MAX_ROW_WIDTH);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEPTH:     r_depth     <= t_depth'(i_cfg_wdata[1:0]);
                CFG_GRAY:      r_gray      <= i_cfg_wdata[0];
                CFG_ROW_WIDTH: r_row_width <= i_cfg_wdata[ROW_W-1:0];
                default: ;     // unused index, write dropped
            endcase
        end
    end

    // zero width counts as one, anything above the maximum is clamped
    always_comb begin
        if (r_row_width == '0) begin
            width_eff = ROW_W'(1);
        end else if (r_row_width > ROW_W'(MAX_ROW_WIDTH)) begin
            width_eff = ROW_W'(MAX_ROW_WIDTH);
        end else begin
            width_eff = r_row_width;
        end
    end

    // input register, pixel slicer, column counter
    pipx_unpack u_unpack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_item     (i_in_data),
        .o_stall    (o_in_stall),
        .i_depth    (r_depth),
        .i_width    (width_eff),
        .i_s2_ready (s2_ready),
        .o_pix      (pix),
        .o_wr       (pal_wr)
    );

    // palette read, gray ramp, output register
    pipx_colour u_colour (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix),
        .i_wr        (pal_wr),
        .i_gray      (r_gray),
        .i_depth     (r_depth),
        .o_s2_ready  (s2_ready),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/pipx_chk.sv */
// pipx_chk: port level checks of the palette expander, bound to the top level
// depends on pipx_pkg and packed_index_palette_expander_top

module pipx_chk
    import pipx_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    // the row end always closes the byte
    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.row_end |-> o_out_data.last_of_byte)
        else $error("row end without last_of_byte");

    // pixels of one byte come out back to back
    a_byte_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last_of_byte |=> o_out_valid)
        else $error("gap inside the pixels of one byte");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind packed_index_palette_expander_top pipx_chk u_pipx_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
